>>> rtl/mrcn_pkg.sv
// Package for the matrix row/column abs-sum norm block.
// Sizes, register indexes, the column memory request type and the arithmetic helpers.
// No dependencies.
package mrcn_pkg;

    localparam int MAX_DIM = 64;
    localparam int POS_W   = $clog2(MAX_DIM);
    localparam int CNT_W   = 7;
    localparam int CMP_W   = (POS_W + 1 > CNT_W) ? POS_W + 1 : CNT_W;
    localparam int ELEM_W  = 16;
    localparam int MAG_W   = ELEM_W + 1;
    localparam int SUM_W   = 22;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic {
        REG_ROW_COUNT = 1'b0,
        REG_COL_COUNT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic             wr_en;
        logic [POS_W-1:0] wr_addr;
        logic             rd_en;
        logic [POS_W-1:0] rd_addr;
    } cmem_req_t;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [MAG_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W+1)'(b);
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    function automatic logic [CMP_W-1:0] clamp_count(input logic [CNT_W-1:0] v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        if (v == '0)
        begin
            return CMP_W'(1);
        end
        else if (w > CMP_W'(MAX_DIM))
        begin
            return CMP_W'(MAX_DIM);
        end
        return w;
    endfunction

endpackage

>>> rtl/mrcn_if.sv
// Request channels of the norm block: element input and norm result.
// Depends on mrcn_pkg.
interface mrcn_elem_if import mrcn_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface mrcn_norm_if import mrcn_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] row_norm;
    logic [SUM_W-1:0] col_norm;

    modport source (output valid, output row_norm, output col_norm, input ready);
    modport sink   (input valid, input row_norm, input col_norm, output ready);
endinterface

>>> rtl/mrcn_colmem.sv
// Column sum store: one write port, one registered read port.
// Read data bypasses a write to the same entry in the same cycle. Depends on mrcn_pkg.
module mrcn_colmem import mrcn_pkg::*;
(
    input  logic             clk,
    input  cmem_req_t        req,
    input  logic [SUM_W-1:0] wr_data,
    output logic [SUM_W-1:0] rd_data
);

    logic [SUM_W-1:0] mem [MAX_DIM];
    logic [SUM_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            if (req.wr_en && (req.wr_addr == req.rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/matrix_row_and_column_abs_sum_norm.sv
// Matrix infinity norm and one norm, top level.
// Depends on mrcn_pkg, mrcn_if and mrcn_colmem.
//
// Usage:
//   Program row_count (address 0) and col_count (address 4) over the APB port,
//   then stream the matrix elements in row-major order on elem. A count of 0
//   counts as 1, one above 64 as 64.
//   After the last element one request appears on norm carrying row_norm
//   (largest absolute row sum) and col_norm (largest absolute column sum);
//   the block then starts over for the next matrix.
// Timing:
//   One element per cycle while elem.ready is high. The result is registered
//   after stage 1. The rate is set by the read-modify-write of the column sum
//   memory (one read and one write port, bypass on the same entry).
// Reset:
//   Both counts return to 1, positions, running sum and maxima to zero. The
//   column memory is not cleared; row 0 overwrites its entries.
// Stall:
//   The result waits in the output register; elements keep flowing until a
//   second result would need that register, then elem.ready drops.
module matrix_row_and_column_abs_sum_norm import mrcn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    mrcn_elem_if.sink          elem,
    mrcn_norm_if.source        norm,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic [CNT_W-1:0] row_count_reg;
    logic [CNT_W-1:0] col_count_reg;
    reg_idx_t         reg_idx;
    logic             cfg_wr;

    logic [POS_W-1:0] row_pos_reg;
    logic [POS_W-1:0] col_pos_reg;
    logic [CMP_W-1:0] rows;
    logic [CMP_W-1:0] cols;
    logic             last_col;
    logic             last_row;
    logic [MAG_W-1:0] mag;
    logic signed [MAG_W-1:0] elem_ext;
    logic             accept;

    logic             s1_valid_reg;
    logic [MAG_W-1:0] s1_mag_reg;
    logic [POS_W-1:0] s1_col_reg;
    logic             s1_first_row_reg;
    logic             s1_last_col_reg;
    logic             s1_last_row_reg;
    logic             s1_res;
    logic             s1_adv;
    logic             s1_fire;

    logic [SUM_W-1:0] rd_data;
    logic [SUM_W-1:0] csum;
    logic [SUM_W-1:0] run_sum;
    logic [SUM_W-1:0] run_reg;
    logic [SUM_W-1:0] row_max_reg;
    logic [SUM_W-1:0] col_max_reg;
    logic [SUM_W-1:0] row_max_next;
    logic [SUM_W-1:0] col_max_next;

    logic             out_valid_reg;
    logic [SUM_W-1:0] row_norm_reg;
    logic [SUM_W-1:0] col_norm_reg;

    cmem_req_t        cmem_req;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CNT_W'(1);
            col_count_reg <= CNT_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_ROW_COUNT: row_count_reg <= pwdata[CNT_W-1:0];
                REG_COL_COUNT: col_count_reg <= pwdata[CNT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ROW_COUNT: prdata = DATA_W'(row_count_reg);
            REG_COL_COUNT: prdata = DATA_W'(col_count_reg);
            default:       prdata = '0;
        endcase
    end

    // stage 0: position tracking and memory read
    assign rows     = clamp_count(row_count_reg);
    assign cols     = clamp_count(col_count_reg);
    assign last_col = (CMP_W'(col_pos_reg) + CMP_W'(1)) >= cols;
    assign last_row = (CMP_W'(row_pos_reg) + CMP_W'(1)) >= rows;
    assign elem_ext = MAG_W'(elem.element_value);
    assign mag      = elem_ext[MAG_W-1] ? MAG_W'(-elem_ext) : MAG_W'(elem_ext);

    assign s1_res     = s1_last_col_reg && s1_last_row_reg;
    assign s1_adv     = !s1_valid_reg || !s1_res || !out_valid_reg || norm.ready;
    assign s1_fire    = s1_valid_reg && s1_adv;
    assign elem.ready = s1_adv;
    assign accept     = elem.valid && s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
        end
        else if (accept)
        begin
            if (!last_col)
            begin
                col_pos_reg <= col_pos_reg + POS_W'(1);
            end
            else
            begin
                col_pos_reg <= '0;
                row_pos_reg <= last_row ? '0 : row_pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_mag_reg       <= mag;
            s1_col_reg       <= col_pos_reg;
            s1_first_row_reg <= (row_pos_reg == '0);
            s1_last_col_reg  <= last_col;
            s1_last_row_reg  <= last_row;
        end
    end

    assign cmem_req.rd_en   = accept;
    assign cmem_req.rd_addr = col_pos_reg;
    assign cmem_req.wr_en   = s1_fire;
    assign cmem_req.wr_addr = s1_col_reg;

    mrcn_colmem u_colmem
    (
        .clk     (clk),
        .req     (cmem_req),
        .wr_data (csum),
        .rd_data (rd_data)
    );

    // stage 1: accumulate and track maxima
    assign csum    = s1_first_row_reg ? SUM_W'(s1_mag_reg) : sat_add(rd_data, s1_mag_reg);
    assign run_sum = sat_add(run_reg, s1_mag_reg);

    assign row_max_next = (s1_last_col_reg && (run_sum > row_max_reg)) ? run_sum : row_max_reg;
    assign col_max_next = (s1_last_row_reg && (csum > col_max_reg)) ? csum : col_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= '0;
            row_max_reg <= '0;
            col_max_reg <= '0;
        end
        else if (s1_fire)
        begin
            run_reg <= s1_last_col_reg ? '0 : run_sum;
            if (s1_res)
            begin
                row_max_reg <= '0;
                col_max_reg <= '0;
            end
            else
            begin
                row_max_reg <= row_max_next;
                col_max_reg <= col_max_next;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_res)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (norm.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_res)
        begin
            row_norm_reg <= row_max_next;
            col_norm_reg <= col_max_next;
        end
    end

    assign norm.valid    = out_valid_reg;
    assign norm.row_norm = row_norm_reg;
    assign norm.col_norm = col_norm_reg;

endmodule

>>> rtl/mrcn_chk.sv
// Port-level checker for the norm block, bound to the top level.
// Depends on mrcn_pkg.
module mrcn_chk import mrcn_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [SUM_W-1:0] row_norm,
    input logic [SUM_W-1:0] col_norm
);

    localparam logic [SUM_W:0] NORM_BOUND = (SUM_W+1)'(MAX_DIM * (1 << (ELEM_W - 1)));

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(row_norm) && $stable(col_norm))
        else $error("result changed while stalled");

    // a new result follows an accepted element
    a_res_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without element");

    // norms stay within the matrix bound
    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, row_norm} <= NORM_BOUND) && ({1'b0, col_norm} <= NORM_BOUND))
        else $error("norm out of range");

    // ready is only withheld while a result waits
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without pending result");

endmodule

bind matrix_row_and_column_abs_sum_norm mrcn_chk u_mrcn_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (elem.valid),
    .in_ready  (elem.ready),
    .out_valid (norm.valid),
    .out_ready (norm.ready),
    .row_norm  (norm.row_norm),
    .col_norm  (norm.col_norm)
);
